// ----- rtl/core/scla_pkg.sv -----
// Shared constants and types for the serial command line assembler.
`default_nettype none
package scla_pkg;
	localparam int unsigned QueueDepth = 1024;
	localparam int unsigned PtrW = $clog2(QueueDepth);
	localparam int unsigned CntW = PtrW + 1;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	localparam logic [7:0] CHR_NUL = 8'h00;
	localparam logic [7:0] CHR_BS  = 8'h08;
	localparam logic [7:0] CHR_TAB = 8'h09;
	localparam logic [7:0] CHR_LF  = 8'h0A;
	localparam logic [7:0] CHR_CR  = 8'h0D;
	localparam logic [7:0] CHR_SP  = 8'h20;
	localparam logic [7:0] CHR_DEL = 8'h7F;

	typedef struct packed {
		logic       cmd;
		logic [7:0] data;
	} item_t;

	typedef struct packed {
		logic            rd_valid;
		logic [7:0]      rd_byte;
		logic            eoc;
		logic            ovf;
		logic [CntW-1:0] chars;
		logic [CntW-1:0] cmds;
	} result_t;
endpackage
`default_nettype wire

// ----- rtl/core/serial_command_line_assembler_top.sv -----
// Top level of the serial command line assembler.
`default_nettype none
// Usage:
//  s_axis: one beat per item. tuser = cmd (0 write byte, 1 read next byte),
//    tdata = data_byte. A beat is taken when tvalid and tready are high.
//  m_axis: one beat per item, carrying read flags and store counts taken
//    after the item. tuser = read_valid, tlast = end_of_command,
//    tdata = {cmds, chars, ovf, read_byte}.
//  cfg_we / cfg_data: write the binary start byte while the block is idle.
// Timing: a write passes the back end states IDLE, WRT and OUT; a read passes
//  IDLE, RD, SKIP and OUT, and repeats RD and SKIP for each leading whitespace
//  byte skipped, as the store read port is registered; a read with no complete
//  command passes IDLE, RD and OUT. A registered queue entry lies between
//  the s_axis beat and the queue head. The back end takes items one at a time
//  in IDLE; a 2-beat queue lets the front take input while the back end works.
// Reset clears all pointers, counts and flags; store contents are undefined
//  until written. A stalled m_axis holds its beat and the back end waits in
//  its output state; the queue fills and then drops s_axis_tready.
module serial_command_line_assembler_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire  [7:0]  cfg_data,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [7:0]  s_axis_tdata,   // data_byte
	input  wire         s_axis_tuser,   // cmd
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic        m_axis_tuser,   // read_valid
	output logic        m_axis_tlast,   // end_of_command
	// read_byte[7:0] overflow_pending[8] buffered_chars[19:9]
	// buffered_cmds[30:20], zero fill to 32
	output logic [31:0] m_axis_tdata
);
	import scla_pkg::*;

	logic [7:0] start_q;
	item_t      in_item, q_item;
	logic       q_valid, q_take;
	result_t    res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) start_q <= 8'h00;
		else if (cfg_we) start_q <= cfg_data;
	end

	assign in_item.cmd  = s_axis_tuser;
	assign in_item.data = s_axis_tdata;

	scla_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item(in_item),
		.q_valid(q_valid), .q_take(q_take), .q_item(q_item)
	);

	scla_back u_back (
		.clk(clk), .arst_n(arst_n), .start_byte(start_q),
		.q_valid(q_valid), .q_take(q_take), .q_item(q_item),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
	);

	assign m_axis_tuser = res.rd_valid;
	assign m_axis_tlast = res.eoc;
	assign m_axis_tdata = {1'b0, res.cmds, res.chars, res.ovf, res.rd_byte};
endmodule
`default_nettype wire

// ----- rtl/core/scla_front.sv -----
// Input stage and two-entry queue holding items for the execution engine.
`default_nettype none
module scla_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  scla_pkg::item_t      in_item,
	output logic                 q_valid,
	input  wire                  q_take,
	output scla_pkg::item_t      q_item
);
	import scla_pkg::*;

	item_t     mem_q [2];
	logic      wr_q, rd_q;
	logic [1:0] cnt_q;
	logic      push;

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_take) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_take};
		end
	end

	a_no_take_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_take |-> q_valid) else $error("take from empty queue");
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count overrun");
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2) |-> !in_ready) else $error("ready while full");
endmodule
`default_nettype wire

// ----- rtl/core/scla_back.sv -----
// Execution engine: store, terminator list and command state machine.
`default_nettype none
module scla_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire [7:0]            start_byte,
	input  wire                  q_valid,
	output logic                 q_take,
	input  scla_pkg::item_t      q_item,
	output logic                 res_valid,
	input  wire                  res_ready,
	output scla_pkg::result_t    res
);
	import scla_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_WRT  = 3'd1;
	localparam logic [2:0] ST_RD   = 3'd2;
	localparam logic [2:0] ST_SKIP = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [7:0]      cmem [QueueDepth];
	logic [PtrW-1:0] tmem [QueueDepth];
	logic [7:0]      crd_q;
	logic [PtrW-1:0] trd_q;

	logic [2:0]      st_q;
	item_t           it_q;
	logic [PtrW-1:0] head_q, mhead_q, roff_q;
	logic [CntW-1:0] fill_q, mcnt_q;
	logic            started_q, lle_q, ovf_q, bin_q;
	logic [1:0]      hdr_q;
	logic [15:0]     brem_q;
	// read flags of the item in progress, held apart from a waiting beat
	logic            rv_q, eoc_q;
	logic [7:0]      rb_q;

	// read ports
	logic [PtrW-1:0] craddr, traddr;
	logic            full, store_ok, cur_cmd;
	logic [PtrW-1:0] last_idx, wr_idx, len;
	logic            is_le, is_bs, is_ws, ovf_n;
	logic [15:0]     brem_n;

	assign full     = (fill_q == CntW'(QueueDepth));
	assign last_idx = head_q + fill_q[PtrW-1:0] - PtrW'(1);
	assign wr_idx   = head_q + fill_q[PtrW-1:0];
	assign len      = trd_q - head_q;
	assign is_le    = it_q.data == CHR_CR || it_q.data == CHR_LF || it_q.data == CHR_NUL;
	assign is_bs    = it_q.data == CHR_BS || it_q.data == CHR_DEL || it_q.data == CHR_NUL;
	assign is_ws    = crd_q == CHR_CR || crd_q == CHR_LF || crd_q == CHR_TAB ||
	                  crd_q == CHR_SP || crd_q == CHR_NUL;
	assign ovf_n    = ovf_q || (full && it_q.data != CHR_BS);
	assign store_ok = !ovf_n;
	assign cur_cmd  = (st_q == ST_IDLE) ? q_item.cmd : it_q.cmd;

	always_comb begin
		// IDLE: preload newest marker (write) or oldest marker (read)
		if (cur_cmd == CMD_READ) traddr = mhead_q;
		else traddr = mhead_q + mcnt_q[PtrW-1:0] - PtrW'(1);
		if (st_q == ST_RD || st_q == ST_SKIP) craddr = head_q + roff_q;
		else craddr = last_idx;
	end

	always_ff @(posedge clk) begin
		trd_q <= tmem[traddr];
		crd_q <= cmem[craddr];
	end

	assign q_take = (st_q == ST_IDLE) && q_valid;

	always_comb begin
		brem_n = brem_q;
		case (hdr_q)
			2'd0:    brem_n = {it_q.data, 8'h00};
			2'd1:    brem_n = brem_q | {8'h00, it_q.data};
			default: brem_n = brem_q - 16'd1;
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_WRT) begin
			if ((bin_q || it_q.data == start_byte) && store_ok)
				cmem[wr_idx] <= it_q.data;
			else if (!bin_q && it_q.data != start_byte && !ovf_n && !is_bs) begin
				if (is_le) begin
					if (!lle_q && !full) begin
						cmem[wr_idx] <= CHR_NUL;
						tmem[mhead_q + mcnt_q[PtrW-1:0]] <= wr_idx;
					end
				end else if (!full) cmem[wr_idx] <= it_q.data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_take) it_q <= q_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; head_q <= '0; mhead_q <= '0; roff_q <= '0;
			fill_q <= '0; mcnt_q <= '0; started_q <= 1'b0; lle_q <= 1'b0;
			ovf_q <= 1'b0; bin_q <= 1'b0; hdr_q <= 2'd0; brem_q <= '0;
			rv_q <= 1'b0; rb_q <= 8'h00; eoc_q <= 1'b0;
			res_valid <= 1'b0; res <= '0;
		end else begin
			res_valid <= (st_q == ST_OUT && (!res_valid || res_ready)) ||
			             (res_valid && !res_ready);
			case (st_q)
				ST_IDLE: if (q_take) st_q <= (q_item.cmd == CMD_READ) ? ST_RD : ST_WRT;
				ST_WRT: begin
					rv_q <= 1'b0; rb_q <= 8'h00; eoc_q <= 1'b0;
					if (bin_q) begin
						ovf_q <= ovf_n;
						brem_q <= brem_n;
						if (hdr_q != 2'd2) hdr_q <= hdr_q + 2'd1;
						if (hdr_q != 2'd0 && brem_n == 16'd0) bin_q <= 1'b0;
						if (store_ok) fill_q <= fill_q + CntW'(1);
					end else if (it_q.data == start_byte) begin
						ovf_q <= ovf_n;
						bin_q <= 1'b1; hdr_q <= 2'd0; brem_q <= '0; lle_q <= 1'b0;
						if (store_ok) fill_q <= fill_q + CntW'(1);
					end else if (ovf_n) begin
						if (is_le) begin
							if (mcnt_q == '0) begin
								fill_q <= '0; roff_q <= '0; started_q <= 1'b0;
							end else
								fill_q <= {1'b0, PtrW'(trd_q - head_q)} + CntW'(1);
							ovf_q <= 1'b0; lle_q <= 1'b1;
						end else begin
							ovf_q <= 1'b1; lle_q <= 1'b0;
						end
					end else if (is_bs) begin
						if (!lle_q && fill_q != '0 &&
						    !(mcnt_q != '0 && trd_q == last_idx))
							fill_q <= fill_q - CntW'(1);
					end else if (is_le) begin
						if (!lle_q) begin
							if (!full) begin
								fill_q <= fill_q + CntW'(1);
								mcnt_q <= mcnt_q + CntW'(1);
							end
							lle_q <= 1'b1;
						end
					end else begin
						if (!full) fill_q <= fill_q + CntW'(1);
						lle_q <= 1'b0;
					end
					st_q <= ST_OUT;
				end
				ST_RD: begin
					if (mcnt_q == '0) begin
						rv_q <= 1'b0; rb_q <= 8'h00; eoc_q <= 1'b0;
						st_q <= ST_OUT;
					end else if (!started_q) st_q <= ST_SKIP;
					else st_q <= ST_SKIP;
				end
				ST_SKIP: begin
					// crd_q holds store[head+roff]
					if (!started_q && roff_q < len && is_ws) begin
						roff_q <= roff_q + PtrW'(1);
						st_q <= ST_RD;
					end else begin
						rv_q <= 1'b1;
						if (roff_q < len) begin
							rb_q <= crd_q; eoc_q <= 1'b0;
							roff_q <= roff_q + PtrW'(1);
							started_q <= 1'b1;
						end else begin
							rb_q <= 8'h00; eoc_q <= 1'b1;
							head_q <= trd_q + PtrW'(1);
							fill_q <= (fill_q >= {1'b0, len} + CntW'(1)) ?
							          fill_q - {1'b0, len} - CntW'(1) : '0;
							mhead_q <= mhead_q + PtrW'(1);
							mcnt_q <= mcnt_q - CntW'(1);
							roff_q <= '0; started_q <= 1'b0;
						end
						st_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!res_valid || res_ready) begin
						res.rd_valid <= rv_q; res.rd_byte <= rb_q; res.eoc <= eoc_q;
						res.ovf <= ovf_q; res.chars <= fill_q; res.cmds <= mcnt_q;
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	a_fill_max: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CntW'(QueueDepth)) else $error("fill overrun");
	a_cmds_le_fill: assert property (@(posedge clk) disable iff (!arst_n)
		mcnt_q <= fill_q) else $error("more commands than bytes");
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_take |=> (st_q == ST_WRT || st_q == ST_RD)) else $error("bad dispatch");
endmodule
`default_nettype wire

// ----- bench/scla_checker.sv -----
// Channel monitor, line assembler predictor and result comparison.
`timescale 1ns / 1ps
module scla_checker (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire  [7:0]  cfg_data,
	input  wire         s_axis_tvalid,
	input  wire         s_axis_tready,
	input  wire  [7:0]  s_axis_tdata,
	input  wire         s_axis_tuser,
	input  wire         m_axis_tvalid,
	input  wire         m_axis_tready,
	input  wire         m_axis_tuser,
	input  wire         m_axis_tlast,
	input  wire  [31:0] m_axis_tdata,
	output int          fails,
	output int          pending
);
	import scla_pkg::*;

	localparam int unsigned D = QueueDepth;
	localparam int unsigned DueDepth = 64;

	logic [7:0]      line_mem [D];
	int unsigned     term_at [D];
	int unsigned     head, fill, nterm, term_head, rd_pos;
	bit              rd_begun, after_eol, ovf, in_bin;
	int unsigned     hdr_cnt;
	logic [15:0]     bin_left;
	logic [7:0]      open_byte;
	result_t         due_ring [DueDepth];
	int unsigned     due_wr, due_rd;

	function automatic bit is_blank(logic [7:0] b);
		return b == CHR_CR || b == CHR_LF || b == CHR_TAB || b == CHR_SP || b == CHR_NUL;
	endfunction

	function automatic int unsigned last_term();
		return term_at[(term_head + nterm - 1) % D];
	endfunction

	function automatic bit keep_byte(logic [7:0] b);
		if (fill >= D) begin
			ovf = 1;
			return 0;
		end
		line_mem[(head + fill) % D] = b;
		fill++;
		return 1;
	endfunction

	function automatic void take_write(logic [7:0] b);
		int unsigned pos, tail;
		if (fill >= D && b != CHR_BS)
			ovf = 1;
		if (in_bin) begin
			if (hdr_cnt == 0) begin
				bin_left = {b, 8'h00};
				hdr_cnt = 1;
			end else if (hdr_cnt == 1) begin
				bin_left = bin_left | b;
				hdr_cnt = 2;
				if (bin_left == 0) in_bin = 0;
			end else begin
				bin_left = bin_left - 1;
				if (bin_left == 0) in_bin = 0;
			end
			if (!ovf) void'(keep_byte(b));
		end else if (b == open_byte) begin
			in_bin = 1;
			hdr_cnt = 0;
			bin_left = 0;
			if (!ovf) void'(keep_byte(b));
			after_eol = 0;
		end else if (ovf) begin
			if (b == CHR_CR || b == CHR_LF || b == CHR_NUL) begin
				if (nterm == 0) begin
					fill = 0;
					rd_pos = 0;
					rd_begun = 0;
				end else begin
					fill = ((last_term() + D - head) % D) + 1;
				end
				ovf = 0;
				after_eol = 1;
			end else begin
				after_eol = 0;
			end
		end else if (b == CHR_BS || b == CHR_DEL || b == CHR_NUL) begin
			if (!after_eol && fill > 0) begin
				tail = (head + fill - 1) % D;
				// never eat into a finished command
				if (!(nterm > 0 && last_term() == tail)) fill--;
			end
		end else if (b == CHR_CR || b == CHR_LF) begin
			if (!after_eol) begin
				pos = (head + fill) % D;
				if (keep_byte(CHR_NUL)) begin
					term_at[(term_head + nterm) % D] = pos;
					nterm++;
				end
				after_eol = 1;
			end
		end else begin
			void'(keep_byte(b));
			after_eol = 0;
		end
	endfunction

	function automatic void take_read(inout result_t r);
		int unsigned tpos, len;
		if (nterm == 0) return;
		tpos = term_at[term_head];
		len = (tpos + D - head) % D;
		if (!rd_begun) begin
			while (rd_pos < len && is_blank(line_mem[(head + rd_pos) % D])) rd_pos++;
			rd_begun = 1;
		end
		r.rd_valid = 1;
		if (rd_pos < len) begin
			r.rd_byte = line_mem[(head + rd_pos) % D];
			rd_pos++;
		end else begin
			r.eoc = 1;
			head = (tpos + 1) % D;
			fill = (fill >= len + 1) ? fill - (len + 1) : 0;
			term_head = (term_head + 1) % D;
			nterm--;
			rd_pos = 0;
			rd_begun = 0;
		end
	endfunction

	function automatic result_t assemble_step(logic c, logic [7:0] b);
		result_t r;
		r = '0;
		if (c == CMD_WRITE) take_write(b);
		else take_read(r);
		r.ovf = ovf;
		r.chars = fill[CntW-1:0];
		r.cmds = nterm[CntW-1:0];
		return r;
	endfunction

	task automatic report(string what, int got, int want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		fails++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want, got;
		if (!arst_n) begin
			head = 0; fill = 0; nterm = 0; term_head = 0; rd_pos = 0;
			rd_begun = 0; after_eol = 0; ovf = 0; in_bin = 0;
			hdr_cnt = 0; bin_left = 0; open_byte = 8'h00;
			due_wr = 0; due_rd = 0;
			fails = 0;
		end else begin
			if (cfg_we) open_byte = cfg_data;
			if (s_axis_tvalid && s_axis_tready) begin
				due_ring[due_wr % DueDepth] = assemble_step(s_axis_tuser, s_axis_tdata);
				due_wr++;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.rd_valid = m_axis_tuser;
				got.rd_byte  = m_axis_tdata[7:0];
				got.eoc      = m_axis_tlast;
				got.ovf      = m_axis_tdata[8];
				got.chars    = m_axis_tdata[19:9];
				got.cmds     = m_axis_tdata[30:20];
				if (due_wr == due_rd) begin
					report("unexpected beat", 1, 0);
				end else begin
					want = due_ring[due_rd % DueDepth];
					due_rd++;
					if (got.rd_valid != want.rd_valid) report("read_valid", got.rd_valid, want.rd_valid);
					if (got.rd_byte != want.rd_byte) report("read_byte", got.rd_byte, want.rd_byte);
					if (got.eoc != want.eoc) report("end_of_command", got.eoc, want.eoc);
					if (got.ovf != want.ovf) report("overflow_pending", got.ovf, want.ovf);
					if (got.chars != want.chars) report("buffered_chars", got.chars, want.chars);
					if (got.cmds != want.cmds) report("buffered_cmds", got.cmds, want.cmds);
				end
			end
		end
		pending = int'(due_wr - due_rd);
	end
endmodule

// ----- bench/tb.sv -----
// Stimulus and verdict for the serial command line assembler.
`timescale 1ns / 1ps
module tb;
	import scla_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [7:0]  cfg_data = '0;
	logic        s_axis_tvalid = 0;
	wire         s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic        s_axis_tuser = 0;
	wire         m_axis_tvalid;
	logic        m_axis_tready = 0;
	wire         m_axis_tuser;
	wire         m_axis_tlast;
	wire  [31:0] m_axis_tdata;
	int          fails, pending;

	int          sent = 0;        // beats accepted so far
	int          tx_idle = 10;    // sender gap chance, percent
	int          rx_idle = 77;    // receiver stall chance, percent
	int          rd_pct = 10;     // chance of a read burst per chunk, percent
	bit          hold_off = 0;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	serial_command_line_assembler_top uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast),
		.m_axis_tdata(m_axis_tdata)
	);

	scla_checker chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast),
		.m_axis_tdata(m_axis_tdata), .fails(fails), .pending(pending)
	);

	// receiver: random stalls, or a forced hold-off
	always @(negedge clk)
		m_axis_tready <= !hold_off && ($urandom_range(99) >= rx_idle);

	// long hold-off mid run so the input queue backs up
	initial begin
		wait (sent >= 700);
		@(negedge clk);
		hold_off = 1;
		repeat (300) @(negedge clk);
		hold_off = 0;
	end

	// regime of idling follows progress
	always @(negedge clk) begin
		if (sent >= 900) begin
			tx_idle = 0;
			rx_idle = 0;
		end else if (sent >= 450) begin
			tx_idle = 77;
			rx_idle = 10;
		end
	end

	// tready is steady between rising edges, so it is looked at on the falling one
	task automatic send(logic c, logic [7:0] d);
		if ($urandom_range(99) < tx_idle) begin
			s_axis_tvalid <= 0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser <= c;
		s_axis_tdata <= d;
		#1;
		while (!s_axis_tready) @(negedge clk);
		@(negedge clk);
		sent++;
	endtask

	task automatic wr(logic [7:0] d);
		send(CMD_WRITE, d);
	endtask

	// only while idle: all results in, then a short settle
	task automatic set_open_byte(logic [7:0] v);
		s_axis_tvalid <= 0;
		wait (pending == 0);
		repeat (20) @(negedge clk);
		cfg_we <= 1;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	// one random chunk: a command line, a binary run, edits, bare line ends, noise or reads
	task automatic random_chunk(logic [7:0] open_v, bit big_bin);
		int k, n;
		logic [7:0] c;
		k = $urandom_range(99);
		if ($urandom_range(99) < rd_pct) begin
			n = $urandom_range(1, 10);
			repeat (n) send(CMD_READ, 8'($urandom_range(255)));
		end
		if (k < 8) begin
			wr(8'($urandom_range(255)));
		end else if (k < 16) begin
			c = ($urandom_range(1)) ? CHR_BS : CHR_DEL;
			wr(c);
		end else if (k < 26) begin
			wr(open_v);
			n = big_bin ? $urandom_range(256, 400) : $urandom_range(0, 5);
			wr(n[15:8]);
			wr(n[7:0]);
			repeat (n) wr(8'($urandom_range(255)));
		end else if (k < 32) begin
			repeat ($urandom_range(1, 3)) wr(($urandom_range(1)) ? CHR_CR : CHR_LF);
		end else begin
			if ($urandom_range(3) == 0) wr(($urandom_range(1)) ? CHR_SP : CHR_TAB);
			n = $urandom_range(1, 12);
			for (int i = 0; i < n; i++) begin
				c = 8'($urandom_range(8'h21, 8'h7E));
				if (c == CHR_DEL || c == open_v) c = "q";
				if ($urandom_range(9) == 0) c = CHR_SP;
				wr(c);
			end
			wr(($urandom_range(1)) ? CHR_CR : CHR_LF);
		end
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// start byte left at NUL, written explicitly anyway
		set_open_byte(CHR_NUL);
		// leading blanks, delete, doubled line end, backspace after line end
		wr(CHR_SP); wr(CHR_TAB); wr("A"); wr("b"); wr(CHR_DEL); wr("c");
		wr(CHR_CR); wr(CHR_LF); wr(CHR_BS);
		repeat (4) send(CMD_READ, 8'hFF);
		// backspace on empty store, zero length binary run, high bytes
		wr(CHR_BS);
		wr(CHR_NUL); wr(8'h00); wr(8'h00);
		wr("x"); wr(CHR_BS);             // backspace never reaches the run
		wr(8'hFF); wr(8'h80); wr(CHR_LF);
		repeat (5) send(CMD_READ, 8'h00);

		while (sent < 400) random_chunk(CHR_NUL, 0);

		// write-heavy phase with a long binary run: drives the store full
		set_open_byte(8'hFF);
		rd_pct = 2;
		random_chunk(8'hFF, 1);
		while (sent < 1150) random_chunk(8'hFF, ($urandom_range(99) == 0));

		// read-heavy phase, mid start byte
		set_open_byte(8'h5A);
		rd_pct = 70;
		while (sent < 1300) random_chunk(8'h5A, 0);
		repeat (40) send(CMD_READ, 8'($urandom_range(255)));
		s_axis_tvalid <= 0;

		wait (pending == 0);
		repeat (50) @(negedge clk);
		if (fails == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("CHECKS FAILED");
		$finish;
	end
endmodule

// ----- files.f -----
rtl/core/scla_pkg.sv
rtl/core/scla_front.sv
rtl/core/scla_back.sv
rtl/core/serial_command_line_assembler_top.sv
bench/scla_checker.sv
bench/tb.sv
